// File: src/lgli_pkg.sv
`default_nettype none

package lgli_pkg;

  // Sample and register widths.
  localparam int SAMPLE_W     = 16;
  localparam int RADIUS_W     = 5;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 1;

  // Largest radius the design supports, and the most results one sample may cause.
  localparam int MAX_RADIUS   = 16;
  localparam int RESULT_LIMIT = 16;
  localparam int RADIUS_CAP   = (MAX_RADIUS < RESULT_LIMIT) ? MAX_RADIUS : RESULT_LIMIT;

  // Counts of held samples and anchor distances run from 0 to RESULT_LIMIT.
  localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

  // Command queue between the front and the back; the depth must be a power of two.
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILL_VALUE = 1'b0,
    CFG_GAP_RADIUS = 1'b1
  } cfg_index_t;

  // One input item.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       line_end;
  } lgli_in_t;

  // One result item.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       was_filled;
    logic                       line_done;
    logic                       run_last;
  } lgli_out_t;

  // Work orders for the back end.
  typedef enum logic {
    OP_EMIT   = 1'b0,
    OP_INTERP = 1'b1
  } cmd_op_t;

  // OP_EMIT releases count fill samples, then the sample itself if with_pass is set.
  // OP_INTERP fills distance-1 samples between anchor and sample, then passes sample.
  typedef struct packed {
    cmd_op_t                    op;
    logic                       with_pass;
    logic                       line_end;
    logic [CNT_W-1:0]           count;
    logic [CNT_W-1:0]           distance;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SAMPLE_W-1:0] anchor;
    logic signed [SAMPLE_W-1:0] fill;
  } cmd_t;

endpackage

`default_nettype wire

// File: src/line_gap_linear_interpolation_unit.sv
// A sample that passes straight through is written into the queue, then popped and registered at the output.
// The back end takes a new command only after its last result; a held missing sample is not queued.
// A filled gap of n samples takes one queue pop, a division, n interpolated results, then the sample.
// The back end handles one queued command at a time; a four-entry queue decouples it from input.
// Reset (rst, synchronous, active high) clears line state, queue, sequencer and output valid,
// and sets fill_value to 0 and gap_radius to 3.
`default_nettype none

module line_gap_linear_interpolation_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire lgli_pkg::lgli_in_t                 in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output lgli_pkg::lgli_out_t                     out_data,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire lgli_pkg::cfg_index_t               cfg_index,
  input  wire logic [lgli_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import lgli_pkg::*;

  logic signed [SAMPLE_W-1:0] fill_value;
  logic [RADIUS_W-1:0]        gap_radius;
  logic [CNT_W-1:0]           eff_radius;
  logic                       q_full;
  logic                       q_empty;
  logic                       push;
  logic                       pop;
  cmd_t                       push_cmd;
  cmd_t                       q_head;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_value <= '0;
      gap_radius <= RADIUS_W'(3);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FILL_VALUE: fill_value <= $signed(cfg_data[SAMPLE_W-1:0]);
        CFG_GAP_RADIUS: gap_radius <= cfg_data[RADIUS_W-1:0];
        default:        fill_value <= fill_value;
      endcase
    end
  end

  // Radius in force: at least one, at most the supported cap.
  always_comb begin
    if (gap_radius > RADIUS_W'(RADIUS_CAP)) begin
      eff_radius = CNT_W'(RADIUS_CAP);
    end else if (gap_radius == '0) begin
      eff_radius = CNT_W'(1);
    end else begin
      eff_radius = CNT_W'(gap_radius);
    end
  end

  lgli_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .fill_value (fill_value),
    .eff_radius (eff_radius),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  lgli_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  lgli_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The queue is empty after reset, so input is open right away.
  a_ready_after_reset: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

  // An interpolated sample is always followed by the closing anchor.
  a_filled_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.was_filled |-> !out_data.run_last)
    else $error("interpolated sample marked as last result");

  // End of line is flagged only on the last result of a sample.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.line_done |-> out_data.run_last)
    else $error("line_done without run_last");

  // The front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("command queue overflow");

endmodule

`default_nettype wire

// File: src/lgli_front.sv
`default_nettype none

module lgli_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire lgli_pkg::lgli_in_t               in_data,
  input  wire logic signed [lgli_pkg::SAMPLE_W-1:0] fill_value,
  input  wire logic [lgli_pkg::CNT_W-1:0]       eff_radius,
  input  wire logic                             q_full,
  output logic                                  push,
  output lgli_pkg::cmd_t                        push_cmd
);
  import lgli_pkg::*;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_ANCHOR,
    MODE_GAP,
    MODE_LONG
  } mode_t;

  mode_t                      mode;
  mode_t                      mode_next;
  logic signed [SAMPLE_W-1:0] anchor;
  logic signed [SAMPLE_W-1:0] anchor_next;
  logic [CNT_W-1:0]           gap;
  logic [CNT_W-1:0]           gap_next;
  logic [CNT_W-1:0]           gap_inc;
  logic                       missing;
  logic                       push_c;
  logic                       accept;

  // The front stalls only when the command queue is full.
  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept && push_c;
  assign missing  = (in_data.sample_in == fill_value);
  assign gap_inc  = gap + CNT_W'(1);

  // Classify the sample and decide what the back end has to emit.
  always_comb begin
    mode_next   = mode;
    anchor_next = anchor;
    gap_next    = gap;
    push_c      = 1'b0;

    push_cmd.op        = OP_EMIT;
    push_cmd.with_pass = 1'b0;
    push_cmd.line_end  = in_data.line_end;
    push_cmd.count     = '0;
    push_cmd.distance  = gap_inc;
    push_cmd.sample    = in_data.sample_in;
    push_cmd.anchor    = anchor;
    push_cmd.fill      = fill_value;

    case (mode)
      MODE_NONE: begin
        push_c             = 1'b1;
        push_cmd.with_pass = 1'b1;
        if (!missing) begin
          anchor_next = in_data.sample_in;
          mode_next   = MODE_ANCHOR;
        end
      end
      MODE_ANCHOR: begin
        if (missing) begin
          if (gap_inc >= eff_radius) begin
            // A radius of one can never be bridged: release at once.
            push_c         = 1'b1;
            push_cmd.count = gap_inc;
            gap_next       = '0;
            mode_next      = MODE_LONG;
          end else begin
            gap_next  = gap_inc;
            mode_next = MODE_GAP;
          end
        end else begin
          push_c             = 1'b1;
          push_cmd.with_pass = 1'b1;
          anchor_next        = in_data.sample_in;
        end
      end
      MODE_GAP: begin
        if (missing) begin
          if (gap_inc >= eff_radius) begin
            push_c         = 1'b1;
            push_cmd.count = gap_inc;
            gap_next       = '0;
            mode_next      = MODE_LONG;
          end else begin
            gap_next = gap_inc;
          end
        end else if (gap_inc > eff_radius) begin
          // The radius shrank while the gap was held: release and pass through.
          push_c             = 1'b1;
          push_cmd.count     = gap;
          push_cmd.with_pass = 1'b1;
          gap_next           = '0;
          mode_next          = MODE_NONE;
        end else begin
          push_c      = 1'b1;
          push_cmd.op = OP_INTERP;
          anchor_next = in_data.sample_in;
          gap_next    = '0;
          mode_next   = MODE_ANCHOR;
        end
      end
      MODE_LONG: begin
        push_c             = 1'b1;
        push_cmd.with_pass = 1'b1;
        if (!missing) begin
          mode_next = MODE_NONE;
        end
      end
      default: begin
        mode_next = MODE_NONE;
      end
    endcase

    // End of line flushes any held gap and clears the line state.
    if (in_data.line_end) begin
      if (mode_next == MODE_GAP) begin
        push_c             = 1'b1;
        push_cmd.count     = gap_next;
        push_cmd.with_pass = 1'b0;
      end
      mode_next   = MODE_NONE;
      anchor_next = '0;
      gap_next    = '0;
    end
  end

  // Line state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_NONE;
      anchor <= '0;
      gap    <= '0;
    end else if (accept) begin
      mode   <= mode_next;
      anchor <= anchor_next;
      gap    <= gap_next;
    end
  end

endmodule

`default_nettype wire

// File: src/lgli_queue.sv
`default_nettype none

module lgli_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire lgli_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output lgli_pkg::cmd_t      head,
  output logic                empty
);
  import lgli_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Command storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count; pointers wrap naturally at the power-of-two depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W + 1)'(1);
        2'b01:   count <= count - (QPTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/lgli_back.sv
`default_nettype none

module lgli_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_empty,
  input  wire lgli_pkg::cmd_t q_head,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output lgli_pkg::lgli_out_t out_data
);
  import lgli_pkg::*;

  localparam int DIV_CNT_W = $clog2(SAMPLE_W);

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_FILL,
    B_INTERP,
    B_PASS
  } bstate_t;

  bstate_t                    state;
  cmd_t                       cmd;
  logic [CNT_W-1:0]           remain;

  // Divider: the quotient shifts into div_num, one bit a cycle.
  logic [SAMPLE_W-1:0]        div_num;
  logic [CNT_W-1:0]           div_rem;
  logic [DIV_CNT_W-1:0]       div_cnt;
  logic                       neg;
  logic [CNT_W:0]             trial;
  logic [CNT_W:0]             trial_sub;
  logic                       trial_ge;

  // Running quotient and remainder of |diff| * k / d.
  logic [SAMPLE_W-1:0]        acc_q;
  logic [CNT_W-1:0]           acc_r;
  logic [SAMPLE_W-1:0]        step_q_sum;
  logic [CNT_W-1:0]           step_r_sum;
  logic                       step_wrap;
  logic [SAMPLE_W-1:0]        step_q;
  logic [CNT_W-1:0]           step_r;
  logic signed [SAMPLE_W:0]   step_ofs;
  logic signed [SAMPLE_W:0]   interp_sum;

  logic signed [SAMPLE_W:0]   head_diff;
  logic signed [SAMPLE_W:0]   head_mag;
  logic                       can_emit;
  logic                       emitting;

  assign can_emit = !out_valid || out_ready;
  assign emitting = can_emit && ((state == B_FILL) || (state == B_INTERP) || (state == B_PASS));
  assign pop      = (state == B_IDLE) && !q_empty;

  // Distance between the anchors and its magnitude, for a command about to start.
  always_comb begin
    head_diff = {q_head.sample[SAMPLE_W-1], q_head.sample}
              - {q_head.anchor[SAMPLE_W-1], q_head.anchor};
    head_mag  = head_diff[SAMPLE_W] ? -head_diff : head_diff;
  end

  // One restoring division step.
  always_comb begin
    trial     = {div_rem, div_num[SAMPLE_W-1]};
    trial_sub = trial - {1'b0, cmd.distance};
    trial_ge  = (trial >= {1'b0, cmd.distance});
  end

  // Next interpolated value: add the per-step quotient and remainder, carry on wrap.
  always_comb begin
    step_q_sum = acc_q + div_num;
    step_r_sum = acc_r + div_rem;
    step_wrap  = (step_r_sum >= cmd.distance);
    step_q     = step_q_sum + SAMPLE_W'(step_wrap);
    step_r     = step_wrap ? (step_r_sum - cmd.distance) : step_r_sum;
    step_ofs   = neg ? -$signed({1'b0, step_q}) : $signed({1'b0, step_q});
    interp_sum = $signed({cmd.anchor[SAMPLE_W-1], cmd.anchor}) + step_ofs;
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      // The output register fills when a result is emitted and empties once taken.
      if (emitting) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            cmd <= q_head;
            if (q_head.op == OP_INTERP) begin
              div_num <= head_mag[SAMPLE_W-1:0];
              div_rem <= '0;
              div_cnt <= '0;
              neg     <= head_diff[SAMPLE_W];
              state   <= B_DIV;
            end else if (q_head.count != '0) begin
              remain <= q_head.count;
              state  <= B_FILL;
            end else begin
              state <= B_PASS;
            end
          end
        end

        B_DIV: begin
          div_num <= {div_num[SAMPLE_W-2:0], trial_ge};
          div_rem <= trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
          div_cnt <= div_cnt + DIV_CNT_W'(1);
          if (div_cnt == DIV_CNT_W'(SAMPLE_W - 1)) begin
            acc_q  <= '0;
            acc_r  <= '0;
            remain <= cmd.distance - CNT_W'(1);
            state  <= B_INTERP;
          end
        end

        B_FILL: begin
          if (can_emit) begin
            out_data.sample_out <= cmd.fill;
            out_data.was_filled <= 1'b0;
            out_data.run_last   <= (remain == CNT_W'(1)) && !cmd.with_pass;
            out_data.line_done  <= (remain == CNT_W'(1)) && !cmd.with_pass && cmd.line_end;
            remain              <= remain - CNT_W'(1);
            if (remain == CNT_W'(1)) begin
              state <= cmd.with_pass ? B_PASS : B_IDLE;
            end
          end
        end

        B_INTERP: begin
          if (can_emit) begin
            out_data.sample_out <= interp_sum[SAMPLE_W-1:0];
            out_data.was_filled <= 1'b1;
            out_data.run_last   <= 1'b0;
            out_data.line_done  <= 1'b0;
            acc_q               <= step_q;
            acc_r               <= step_r;
            remain              <= remain - CNT_W'(1);
            if (remain == CNT_W'(1)) begin
              state <= B_PASS;
            end
          end
        end

        B_PASS: begin
          if (can_emit) begin
            out_data.sample_out <= cmd.sample;
            out_data.was_filled <= 1'b0;
            out_data.run_last   <= 1'b1;
            out_data.line_done  <= cmd.line_end;
            state               <= B_IDLE;
          end
        end

        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
